FILE: src/serp_pkg.sv
// ----------------------------------------------------------------------------
// serp_pkg
// Types, constants and S-box functions for the Serpent block cipher unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package serp_pkg;

  localparam logic [31:0] Phi = 32'h9E3779B9;
  localparam int unsigned NumRounds = 32;
  localparam int unsigned NumRkeys = 33;

  localparam logic [2:0] RegKey0 = 3'd0;
  localparam logic [2:0] RegKey1 = 3'd1;
  localparam logic [2:0] RegKey2 = 3'd2;
  localparam logic [2:0] RegKey3 = 3'd3;
  localparam logic [2:0] RegKlen = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KINIT,
    ST_KEXP,
    ST_ENC,
    ST_DEC,
    ST_DONE
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic       load;      // capture block and mode
    logic       kinit;     // seed prekey window
    logic       kstep;     // one round key (four prekey words)
    logic       rstep;     // one cipher round
    logic [5:0] idx;       // round / key index
    logic       last;      // final round of the block
    logic [5:0] nidx;      // index for the next cycle
    logic       ndec;      // direction for the next cycle
  } serp_cmd_t;

  function automatic logic [3:0] sbox_f(input logic [2:0] s, input logic [3:0] v);
    logic [63:0] t;
    begin
      unique case (s)
        3'd0: t = 64'hC90724DEB56A1F83;
        3'd1: t = 64'h43D68EB1A50972CF;
        3'd2: t = 64'h25B04E1DFAC39768;
        3'd3: t = 64'hE57A421D369C8BF0;
        3'd4: t = 64'hD7E9A4526B0C38F1;
        3'd5: t = 64'h176D8E30C9A4B25F;
        3'd6: t = 64'h0A3DF19EB6485C27;
        default: t = 64'h6539AC47B28E0FD1;
      endcase
      sbox_f = t[{v, 2'b00} +: 4];
    end
  endfunction

  function automatic logic [3:0] sbox_i(input logic [2:0] s, input logic [3:0] v);
    logic [3:0] r;
    begin
      r = 4'd0;
      for (int k = 0; k < 16; k++) begin
        if (sbox_f(s, 4'(k)) == v) r = 4'(k);
      end
      sbox_i = r;
    end
  endfunction

  function automatic logic [127:0] slice(input logic [2:0] s, input logic inv,
                                         input logic [127:0] x);
    logic [127:0] y;
    logic [3:0] n;
    logic [3:0] o;
    begin
      y = '0;
      for (int b = 0; b < 32; b++) begin
        n = {x[96+b], x[64+b], x[32+b], x[b]};
        o = inv ? sbox_i(s, n) : sbox_f(s, n);
        y[b] = o[0]; y[32+b] = o[1]; y[64+b] = o[2]; y[96+b] = o[3];
      end
      slice = y;
    end
  endfunction

  function automatic logic [31:0] rl(input logic [31:0] x, input int unsigned n);
    rl = (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [127:0] lin_fwd(input logic [127:0] v);
    logic [31:0] a, b, c, d;
    begin
      a = v[31:0]; b = v[63:32]; c = v[95:64]; d = v[127:96];
      a = rl(a, 13); c = rl(c, 3);
      b = b ^ a ^ c; d = d ^ c ^ (a << 3);
      b = rl(b, 1); d = rl(d, 7);
      a = a ^ b ^ d; c = c ^ d ^ (b << 7);
      a = rl(a, 5); c = rl(c, 22);
      lin_fwd = {d, c, b, a};
    end
  endfunction

  function automatic logic [127:0] lin_inv(input logic [127:0] v);
    logic [31:0] a, b, c, d;
    begin
      a = v[31:0]; b = v[63:32]; c = v[95:64]; d = v[127:96];
      c = rl(c, 10); a = rl(a, 27);
      c = c ^ d ^ (b << 7); a = a ^ b ^ d;
      d = rl(d, 25); b = rl(b, 31);
      d = d ^ c ^ (a << 3); b = b ^ a ^ c;
      c = rl(c, 29); a = rl(a, 19);
      lin_inv = {d, c, b, a};
    end
  endfunction

endpackage
`default_nettype wire

FILE: src/serp_ctrl.sv
// ----------------------------------------------------------------------------
// serp_ctrl
// Sequencer: key expansion on demand, then the cipher rounds of each block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module serp_ctrl import serp_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start_i,
  input  wire logic      mode_i,
  input  wire logic      key_wr_i,
  input  wire logic      out_free_i,
  output serp_cmd_t      cmd_o,
  output logic           busy_o,
  output logic           done_o
);

  state_e     state_q, state_d;
  logic [5:0] cnt_q, cnt_d;
  logic       kval_q, kval_d;
  logic       dec_q, dec_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    kval_d  = kval_q;
    dec_d   = dec_q;
    if (key_wr_i) kval_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          dec_d   = mode_i;
          state_d = kval_q ? (mode_i ? ST_DEC : ST_ENC) : ST_KINIT;
          cnt_d   = (kval_q && mode_i) ? 6'd32 : 6'd0;
        end
      end
      ST_KINIT: begin
        state_d = ST_KEXP;
        cnt_d   = 6'd0;
      end
      ST_KEXP: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd32) begin
          kval_d  = 1'b1;
          state_d = dec_q ? ST_DEC : ST_ENC;
          cnt_d   = dec_q ? 6'd32 : 6'd0;
        end
      end
      ST_ENC: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd31) state_d = ST_DONE;
      end
      ST_DEC: begin
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd1) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = (state_q != ST_IDLE);
    done_o = 1'b0;
    cmd_o.idx  = cnt_q;
    cmd_o.nidx = cnt_d;
    cmd_o.ndec = dec_d;
    unique case (state_q)
      ST_IDLE:  cmd_o.load  = start_i;
      ST_KINIT: cmd_o.kinit = 1'b1;
      ST_KEXP:  cmd_o.kstep = 1'b1;
      ST_ENC: begin
        cmd_o.rstep = 1'b1;
        cmd_o.last  = (cnt_q == 6'd31);
      end
      ST_DEC: begin
        cmd_o.rstep = 1'b1;
        cmd_o.last  = (cnt_q == 6'd1);
      end
      ST_DONE: done_o = out_free_i;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      kval_q  <= 1'b0;
      dec_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      kval_q  <= kval_d;
      dec_q   <= dec_d;
    end
  end

endmodule
`default_nettype wire

FILE: src/serp_dp.sv
// ----------------------------------------------------------------------------
// serp_dp
// Datapath: prekey window, round key memory and one cipher round a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module serp_dp import serp_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         dec_i,
  input  wire logic [127:0] blk_i,
  input  wire logic [255:0] key_i,
  input  wire logic [1:0]   klen_i,
  input  serp_cmd_t         cmd_i,
  output logic [127:0]      res_o
);

  logic [31:0]  win_q [8];
  logic [127:0] rk_mem [NumRkeys-1];
  logic [127:0] rk_top_q;
  logic [127:0] rk_q;
  logic [127:0] x_q, x_d;
  logic         dec_q;
  logic [127:0] grp, t;
  logic [31:0]  w [4];
  logic [2:0]   sb;
  logic [5:0]   ki;
  logic [5:0]   nra;
  logic [4:0]   raddr;
  logic [3:0]   nw;

  // key schedule: four prekey words per cycle, window shifts by four
  always_comb begin
    w[0] = rl(win_q[0] ^ win_q[3] ^ win_q[5] ^ win_q[7] ^ Phi ^
              {24'd0, cmd_i.idx, 2'd0}, 11);
    w[1] = rl(win_q[1] ^ win_q[4] ^ win_q[6] ^ w[0] ^ Phi ^
              {24'd0, cmd_i.idx, 2'd1}, 11);
    w[2] = rl(win_q[2] ^ win_q[5] ^ win_q[7] ^ w[1] ^ Phi ^
              {24'd0, cmd_i.idx, 2'd2}, 11);
    w[3] = rl(win_q[3] ^ win_q[6] ^ w[0] ^ w[2] ^ Phi ^
              {24'd0, cmd_i.idx, 2'd3}, 11);
    grp = slice(3'(3'd3 - cmd_i.idx[2:0]), 1'b0, {w[3], w[2], w[1], w[0]});
  end

  always_comb begin
    nw = (klen_i == 2'd0) ? 4'd4 : (klen_i == 2'd1) ? 4'd6 : 4'd8;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.kinit) begin
      for (int i = 0; i < 8; i++) begin
        win_q[i] <= (4'(i) < nw) ? key_i[32*i +: 32] : ((4'(i) == nw) ? 32'd1 : 32'd0);
      end
    end else if (cmd_i.kstep) begin
      for (int i = 0; i < 4; i++) begin
        win_q[i]   <= win_q[i+4];
        win_q[i+4] <= w[i];
      end
      if (cmd_i.idx == 6'd32) rk_top_q <= grp;
      else rk_mem[cmd_i.idx[4:0]] <= grp;
    end
  end

  // round key for the next cycle; last key held apart
  assign nra   = cmd_i.ndec ? (cmd_i.nidx - 6'd1) : cmd_i.nidx;
  assign raddr = nra[4:0];

  always_ff @(posedge clk_i) begin
    rk_q <= rk_mem[raddr];
  end

  assign ki = cmd_i.idx;
  assign sb = dec_q ? 3'(ki - 6'd1) : ki[2:0];

  always_comb begin
    t = '0;
    if (!dec_q) begin
      t   = slice(sb, 1'b0, x_q ^ rk_q);
      x_d = cmd_i.last ? (t ^ rk_top_q) : lin_fwd(t);
    end else if (ki == 6'd32) begin
      x_d = slice(3'd7, 1'b1, x_q ^ rk_top_q) ^ rk_q;
    end else begin
      x_d = slice(sb, 1'b1, lin_inv(x_q)) ^ rk_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q   <= blk_i;
      dec_q <= dec_i;
    end else if (cmd_i.rstep) begin
      x_q <= x_d;
    end
  end

  assign res_o = x_q;

endmodule
`default_nettype wire

FILE: src/serpent_block_cipher_unit.sv
// ----------------------------------------------------------------------------
// serpent_block_cipher_unit
// Serpent cipher, 128/192/256-bit key over APB, blocks over streams.
// ----------------------------------------------------------------------------
// One block at a time. A block runs its rounds after load, then the hand-off;
// the first block after a key write first expands the key
// (one round key a cycle into the round key store). The round unit is shared by
// all rounds, so a new block is not taken until the last one is handed off.
`timescale 1ns / 1ps
`default_nettype none
module serpent_block_cipher_unit import serp_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         psel_i,
  input  wire logic         penable_i,
  input  wire logic         pwrite_i,
  input  wire logic [5:0]   paddr_i,
  input  wire logic [63:0]  pwdata_i,
  output logic [63:0]       prdata_o,
  output logic              pready_o,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  wire logic [127:0] s_axis_tdata_i,  // block_low, block_high
  input  wire logic         s_axis_tuser_i,  // mode
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  output logic [127:0]      m_axis_tdata_o   // result_low, result_high
);

  logic [63:0]  key_q [4];
  logic [1:0]   klen_q;
  logic         wr;
  logic [2:0]   ra;
  logic         busy, done, ovalid_q;
  logic [127:0] res, odata_q;
  serp_cmd_t    cmd;

  assign pready_o = 1'b1;
  assign wr = psel_i && penable_i && pwrite_i;
  assign ra = paddr_i[5:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) key_q[i] <= '0;
      klen_q <= '0;
    end else if (wr) begin
      unique case (ra)
        RegKey0: key_q[0] <= pwdata_i;
        RegKey1: key_q[1] <= pwdata_i;
        RegKey2: key_q[2] <= pwdata_i;
        RegKey3: key_q[3] <= pwdata_i;
        RegKlen: klen_q   <= pwdata_i[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ra)
      RegKey0: prdata_o = key_q[0];
      RegKey1: prdata_o = key_q[1];
      RegKey2: prdata_o = key_q[2];
      RegKey3: prdata_o = key_q[3];
      RegKlen: prdata_o = {62'd0, klen_q};
      default: prdata_o = '0;
    endcase
  end

  assign s_axis_tready_o = !busy;

  serp_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .start_i   (s_axis_tvalid_i && !busy),
    .mode_i    (s_axis_tuser_i),
    .key_wr_i  (wr && ra <= RegKlen),
    .out_free_i(!ovalid_q || m_axis_tready_i),
    .cmd_o     (cmd),
    .busy_o    (busy),
    .done_o    (done)
  );

  serp_dp u_dp (
    .clk_i,
    .dec_i (s_axis_tuser_i),
    .blk_i (s_axis_tdata_i),
    .key_i ({key_q[3], key_q[2], key_q[1], key_q[0]}),
    .klen_i(klen_q),
    .cmd_i (cmd),
    .res_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (done) begin
      ovalid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) odata_q <= res;
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = odata_q;

endmodule
`default_nettype wire

FILE: src/serp_chk.sv
// ----------------------------------------------------------------------------
// serp_chk
// Port-level checks for the Serpent unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module serp_chk (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tvalid_i,
  input wire logic         s_axis_tready_o,
  input wire logic         m_axis_tvalid_o,
  input wire logic         m_axis_tready_i,
  input wire logic [127:0] m_axis_tdata_o,
  input wire logic         pready_o
);
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output dropped");
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("second word taken while busy");
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> ##30 !m_axis_tvalid_o || $past(m_axis_tvalid_o))
    else $error("result too early");
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni) pready_o)
    else $error("pready low");
endmodule

bind serpent_block_cipher_unit serp_chk u_chk (.*);
`default_nettype wire

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Serpent block cipher unit. The key registers are
// written over APB for several key lengths and patterns. Directed and random
// blocks go in both directions over the input stream, with random bursts and
// gaps, while the output side stalls on its own pattern. A local bitslice
// Serpent model predicts every result word, and a monitor checks the fields.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;
  import serp_pkg::*;

  localparam int unsigned IdleLimit = 3000;
  localparam int unsigned SettleCycles = 80;

  localparam logic [3:0] SBOX_TAB [0:7][0:15] = '{
    '{4'd3, 4'd8, 4'd15, 4'd1, 4'd10, 4'd6, 4'd5, 4'd11,
      4'd14, 4'd13, 4'd4, 4'd2, 4'd7, 4'd0, 4'd9, 4'd12},
    '{4'd15, 4'd12, 4'd2, 4'd7, 4'd9, 4'd0, 4'd5, 4'd10,
      4'd1, 4'd11, 4'd14, 4'd8, 4'd6, 4'd13, 4'd3, 4'd4},
    '{4'd8, 4'd6, 4'd7, 4'd9, 4'd3, 4'd12, 4'd10, 4'd15,
      4'd13, 4'd1, 4'd14, 4'd4, 4'd0, 4'd11, 4'd5, 4'd2},
    '{4'd0, 4'd15, 4'd11, 4'd8, 4'd12, 4'd9, 4'd6, 4'd3,
      4'd13, 4'd1, 4'd2, 4'd4, 4'd10, 4'd7, 4'd5, 4'd14},
    '{4'd1, 4'd15, 4'd8, 4'd3, 4'd12, 4'd0, 4'd11, 4'd6,
      4'd2, 4'd5, 4'd4, 4'd10, 4'd9, 4'd14, 4'd7, 4'd13},
    '{4'd15, 4'd5, 4'd2, 4'd11, 4'd4, 4'd10, 4'd9, 4'd12,
      4'd0, 4'd3, 4'd14, 4'd8, 4'd13, 4'd6, 4'd7, 4'd1},
    '{4'd7, 4'd2, 4'd12, 4'd5, 4'd8, 4'd4, 4'd6, 4'd11,
      4'd14, 4'd9, 4'd1, 4'd15, 4'd13, 4'd3, 4'd10, 4'd0},
    '{4'd1, 4'd13, 4'd15, 4'd0, 4'd14, 4'd8, 4'd2, 4'd11,
      4'd7, 4'd4, 4'd12, 4'd10, 4'd9, 4'd3, 4'd5, 4'd6}
  };

  localparam logic MODE_ENC = 1'b0;
  localparam logic MODE_DEC = 1'b1;

  typedef struct {
    logic         mode;
    logic [127:0] blk;
    bit           drain;
  } blk_word_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         psel_i = 1'b0;
  logic         penable_i = 1'b0;
  logic         pwrite_i = 1'b0;
  logic [5:0]   paddr_i = '0;
  logic [63:0]  pwdata_i = '0;
  logic [63:0]  prdata_o;
  logic         pready_o;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [127:0] s_axis_tdata_i = '0;  // block_low, block_high
  logic         s_axis_tuser_i = 1'b0;  // mode
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [127:0] m_axis_tdata_o;  // result_low, result_high

  serpent_block_cipher_unit dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // cipher model state
  logic [63:0]  key_reg [4];
  logic [1:0]   klen_reg;
  bit           keys_stale = 1'b1;
  logic [127:0] round_key [33];

  blk_word_t    blk_q[$];
  logic [127:0] result_q[$];

  int unsigned  errors = 0;
  int unsigned  n_enc = 0, n_dec = 0, n_keys = 0, n_results = 0;
  int unsigned  in_acc = 0, in_seen = 0;
  int unsigned  idle_cycles = 0, cyc = 0;
  bit           apb_done = 1'b0;

  function automatic logic [31:0] rol32(logic [31:0] v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic logic [3:0] sbox_inv(int s, logic [3:0] v);
    logic [3:0] r;
    r = '0;
    for (int k = 0; k < 16; k++) if (SBOX_TAB[s][k] == v) r = 4'(k);
    return r;
  endfunction

  function automatic logic [127:0] sbox_layer(int s, bit inv, logic [127:0] v);
    logic [127:0] y;
    logic [3:0]   nib, o;
    y = '0;
    for (int b = 0; b < 32; b++) begin
      nib = {v[96+b], v[64+b], v[32+b], v[b]};
      o = inv ? sbox_inv(s, nib) : SBOX_TAB[s][nib];
      y[b] = o[0]; y[32+b] = o[1]; y[64+b] = o[2]; y[96+b] = o[3];
    end
    return y;
  endfunction

  function automatic logic [127:0] lt_fwd(logic [127:0] v);
    logic [31:0] a, b, c, d;
    {d, c, b, a} = v;
    a = rol32(a, 13); c = rol32(c, 3);
    b = b ^ a ^ c; d = d ^ c ^ (a << 3);
    b = rol32(b, 1); d = rol32(d, 7);
    a = a ^ b ^ d; c = c ^ d ^ (b << 7);
    a = rol32(a, 5); c = rol32(c, 22);
    return {d, c, b, a};
  endfunction

  function automatic logic [127:0] lt_inv(logic [127:0] v);
    logic [31:0] a, b, c, d;
    {d, c, b, a} = v;
    c = rol32(c, 10); a = rol32(a, 27);
    c = c ^ d ^ (b << 7); a = a ^ b ^ d;
    d = rol32(d, 25); b = rol32(b, 31);
    d = d ^ c ^ (a << 3); b = b ^ a ^ c;
    c = rol32(c, 29); a = rol32(a, 19);
    return {d, c, b, a};
  endfunction

  function automatic void expand_round_keys();
    logic [31:0]  w [8];
    logic [31:0]  t;
    logic [127:0] grp;
    int           nwords;
    nwords = (klen_reg == 2'd0) ? 4 : (klen_reg == 2'd1) ? 6 : 8;
    for (int i = 0; i < 8; i++) begin
      if (i < nwords) w[i] = key_reg[i/2][32*(i%2) +: 32];
      else w[i] = (i == nwords) ? 32'd1 : 32'd0;
    end
    grp = '0;
    for (int i = 0; i < 132; i++) begin
      t = w[i%8] ^ w[(i+3)%8] ^ w[(i+5)%8] ^ w[(i+7)%8] ^ Phi ^ 32'(i);
      t = rol32(t, 11);
      w[i%8] = t;
      grp[32*(i%4) +: 32] = t;
      if (i % 4 == 3) round_key[i/4] = sbox_layer((35 - i/4) % 8, 1'b0, grp);
    end
    keys_stale = 1'b0;
  endfunction

  function automatic logic [127:0] serpent_block(logic mode, logic [127:0] v);
    if (keys_stale) expand_round_keys();
    if (mode == MODE_ENC) begin
      for (int r = 0; r < 31; r++) v = lt_fwd(sbox_layer(r % 8, 1'b0, v ^ round_key[r]));
      v = sbox_layer(7, 1'b0, v ^ round_key[31]) ^ round_key[32];
    end else begin
      v = sbox_layer(7, 1'b1, v ^ round_key[32]) ^ round_key[31];
      for (int r = 30; r >= 0; r--) v = sbox_layer(r % 8, 1'b1, lt_inv(v)) ^ round_key[r];
    end
    return v;
  endfunction

  // input side: acceptance and prediction
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      result_q.push_back(serpent_block(s_axis_tuser_i, s_axis_tdata_i));
      if (s_axis_tuser_i == MODE_ENC) n_enc++; else n_dec++;
      in_acc++;
    end
  end

  // driver: bursts and gaps
  int unsigned burst_left = 1, gap_left = 0;
  always @(negedge clk_i) begin
    logic      v;
    blk_word_t w;
    v = s_axis_tvalid_i;
    if (rst_ni && !(s_axis_tvalid_i && in_acc == in_seen)) begin
      in_seen = in_acc;
      v = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (blk_q.size() > 0 && !(blk_q[0].drain && result_q.size() > 0)) begin
        w = blk_q.pop_front();
        s_axis_tdata_i <= w.blk;
        s_axis_tuser_i <= w.mode;
        v = 1'b1;
        if (--burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 40) : 0;
        end
      end
    end
    s_axis_tvalid_i <= v;
  end

  // receiver stall pattern, stepping through four characters in turn
  always @(negedge clk_i) begin
    case ((cyc / 400) % 4)
      0: m_axis_tready_i <= 1'b1;
      1: m_axis_tready_i <= $urandom_range(0, 1);
      2: m_axis_tready_i <= (cyc % 16) >= 11;
      default: m_axis_tready_i <= $urandom_range(0, 7) == 0;
    endcase
  end

  // monitor and watchdog
  always @(posedge clk_i) begin
    logic [127:0] e;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      n_results++;
      if (result_q.size() == 0) begin
        $error("unexpected result word %h", m_axis_tdata_o);
        errors++;
      end else begin
        e = result_q.pop_front();
        if (m_axis_tdata_o[63:0] !== e[63:0]) begin
          $error("result_low: expected %h got %h", e[63:0], m_axis_tdata_o[63:0]);
          errors++;
        end
        if (m_axis_tdata_o[127:64] !== e[127:64]) begin
          $error("result_high: expected %h got %h", e[127:64], m_axis_tdata_o[127:64]);
          errors++;
        end
      end
    end
    if ((m_axis_tvalid_o && m_axis_tready_i) || (s_axis_tvalid_i && s_axis_tready_o)
        || (psel_i && penable_i) || !rst_ni || apb_done)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog: no activity for %0d cycles", IdleLimit);
      $display("testbench: FAIL");
      $finish;
    end
  end

  task automatic apb_write(int idx, logic [63:0] val);
    @(negedge clk_i);
    psel_i <= 1'b1; penable_i <= 1'b0; pwrite_i <= 1'b1;
    paddr_i <= 6'(idx * 8); pwdata_i <= val;
    @(negedge clk_i);
    penable_i <= 1'b1;
    @(posedge clk_i);
    while (!pready_o) @(posedge clk_i);
    if (idx < 4) key_reg[idx] = val;
    else if (idx == int'(RegKlen)) klen_reg = val[1:0];
    if (idx <= int'(RegKlen)) keys_stale = 1'b1;
    @(negedge clk_i);
    psel_i <= 1'b0; penable_i <= 1'b0; pwrite_i <= 1'b0;
  endtask

  task automatic set_key(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2,
                         logic [63:0] k3, logic [1:0] code);
    apb_write(int'(RegKey0), k0);
    apb_write(int'(RegKey1), k1);
    apb_write(int'(RegKey2), k2);
    apb_write(int'(RegKey3), k3);
    apb_write(int'(RegKlen), 64'(code));
    n_keys++;
  endtask

  task automatic queue_word(logic mode, logic [127:0] b, bit drain = 1'b0);
    blk_word_t w;
    w.mode = mode; w.blk = b; w.drain = drain;
    blk_q.push_back(w);
  endtask

  function automatic logic [127:0] rand128();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  task automatic queue_random(int n);
    logic [127:0] b;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: b = '0;
        1: b = '1;
        2: b = 128'd1 << $urandom_range(0, 127);
        default: b = rand128();
      endcase
      queue_word($urandom_range(0, 1), b, i == n / 2);
    end
  endtask

  task automatic wait_idle();
    while (blk_q.size() > 0 || result_q.size() > 0 || s_axis_tvalid_i) @(posedge clk_i);
    apb_done = 1'b1;
    repeat (SettleCycles) @(posedge clk_i);
    apb_done = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < 4; i++) key_reg[i] = '0;
    klen_reg = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset key: all zero, 128-bit
    for (int m = 0; m < 2; m++) begin
      queue_word(m, '0);
      queue_word(m, '1);
      queue_word(m, {64'h0123456789ABCDEF, 64'hFEDCBA9876543210});
      queue_word(m, 128'd1);
      queue_word(m, 128'd1 << 127);
    end
    queue_word(MODE_ENC, rand128(), 1'b1);
    queue_word(MODE_DEC, rand128());
    queue_random(150);
    wait_idle();

    set_key('1, '1, '1, '1, 2'd2);
    queue_word(MODE_ENC, '0); queue_word(MODE_DEC, '1);
    queue_random(150);
    wait_idle();

    // 192-bit key with junk in the unused top word
    set_key({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
            '1, 2'd1);
    queue_random(150);
    wait_idle();

    // writes past the register list leave the round keys alone
    apb_write(5, '1); apb_write(6, '1); apb_write(7, '1);
    queue_random(60);
    wait_idle();

    // code three acts as a 256-bit key
    set_key({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
            {$urandom, $urandom}, 2'd3);
    queue_random(150);
    wait_idle();

    set_key({$urandom, $urandom}, {$urandom, $urandom}, '1, '1, 2'd0);
    queue_random(150);
    wait_idle();

    set_key('0, '0, '0, '0, 2'd2);
    queue_random(80);
    wait_idle();

    // single register change, key length only
    apb_write(int'(RegKlen), 64'd1);
    queue_random(80);
    wait_idle();

    if (result_q.size() != 0) begin
      $error("%0d expected result words never arrived", result_q.size());
      errors++;
    end
    $display("covered %0d encrypt and %0d decrypt blocks, %0d result words, %0d keys",
             n_enc, n_dec, n_results, n_keys);
    $display("key lengths 128/192/256 and code three, junk key bits, unmapped writes");
    if (errors == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end

endmodule
